FILE: rtl/imconv_pkg.sv
// Shared types and constants of the image convolution block.
`timescale 1ns / 1ps
`default_nettype none

package imconv_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_DRAIN = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KROWS  = 2'd2;
  localparam logic [1:0] REG_KCOLS  = 2'd3;

  localparam int CFG_BITS     = 13;
  localparam int IDX_BITS     = 2;
  localparam int WIDTH_BITS   = 11;
  localparam int HEIGHT_BITS  = 13;
  localparam int KSIZE_BITS   = 3;
  localparam int PIX_BITS     = 8;
  localparam int CIDX_BITS    = 5;
  localparam int ROW_OUT_BITS = 12;
  localparam int COL_OUT_BITS = 10;
  localparam int MAX_HEIGHT   = 4096;
  localparam int ROUND_HALF   = 128;
  localparam int FRAC_BITS    = 8;
  localparam int PIX_MAX      = 255;

  // Control that every window cell sees in a cycle.
  typedef struct packed {
    logic shift;
    logic clear;
    logic insert;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/imconv_line_mem.sv
// One row bank of the line store: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module imconv_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                               clk,
  input  wire logic                               we,
  input  wire logic [AW-1:0]                      waddr,
  input  wire logic [imconv_pkg::PIX_BITS-1:0]    wdata,
  input  wire logic                               re,
  input  wire logic [AW-1:0]                      raddr,
  output logic      [imconv_pkg::PIX_BITS-1:0]    rdata
);

  logic [imconv_pkg::PIX_BITS-1:0] mem [DEPTH];

  // A read in the same cycle as a write to the same entry returns the old value.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/imconv_cell.sv
// One window column cell: pixel column, its products and its column sum.
`timescale 1ns / 1ps
`default_nettype none

module imconv_cell #(
  parameter int MAX_KERNEL = 5,
  parameter int COEF_BITS  = 16,
  parameter int CSW        = 28
) (
  input  wire logic                                                clk,
  input  wire logic                                                en,
  input  wire imconv_pkg::cell_ctrl_t                              ctrl,
  input  wire logic [MAX_KERNEL-1:0][imconv_pkg::PIX_BITS-1:0]     neigh_in,
  input  wire logic [MAX_KERNEL-1:0][imconv_pkg::PIX_BITS-1:0]     new_col,
  input  wire logic [MAX_KERNEL-1:0][COEF_BITS-1:0]                coef,
  output logic      [MAX_KERNEL-1:0][imconv_pkg::PIX_BITS-1:0]     pix,
  output logic signed [CSW-1:0]                                    col_sum
);

  localparam int PW = COEF_BITS + imconv_pkg::PIX_BITS + 1;

  logic signed [PW-1:0]  prod [MAX_KERNEL];
  logic signed [CSW-1:0] acc;

  always_comb begin
    acc = '0;
    for (int i = 0; i < MAX_KERNEL; i++) begin
      acc = acc + CSW'(prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < MAX_KERNEL; i++) begin
        if (ctrl.shift) begin
          if (ctrl.insert) begin
            pix[i] <= new_col[i];
          end else if (ctrl.clear) begin
            pix[i] <= '0;
          end else begin
            pix[i] <= neigh_in[i];
          end
        end
        prod[i] <= $signed({1'b0, pix[i]}) * $signed(coef[i]);
      end
      col_sum <= acc;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/image_convolution_2d_top.sv
// Top level of the 2-D convolution block with zero padding.
// Pipeline: an item that releases a result starts a fetch job; the result then passes
// the fetch sequencer, fetch, window, product, column sum and total registers.
// Throughput: one item per cycle while the output is not stalled and no coefficient load
// waits; at the start of each output row the input is stalled while the window is filled.
// Reset (rst, synchronous, active high) clears the coefficients, positions,
// valid flags and restores the register defaults; the line store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module image_convolution_2d_top #(
  parameter int MAX_KERNEL = 5,
  parameter int MAX_WIDTH  = 1024,
  parameter int COEF_BITS  = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  // Configuration write port.
  input  wire logic                                        cfg_we,
  input  wire logic [imconv_pkg::IDX_BITS-1:0]             cfg_index,
  input  wire logic [imconv_pkg::CFG_BITS-1:0]             cfg_data,
  // Input item channel.
  input  wire logic                                        in_valid,
  output logic                                             in_stall,
  input  wire logic [1:0]                                  command,
  input  wire logic [imconv_pkg::CIDX_BITS-1:0]            coeff_index,
  input  wire logic [COEF_BITS-1:0]                        coeff_value,
  input  wire logic [imconv_pkg::PIX_BITS-1:0]             pixel_in,
  // Result item channel.
  output logic                                             out_valid,
  input  wire logic                                        out_stall,
  output logic [imconv_pkg::PIX_BITS-1:0]                  pixel_out,
  output logic [imconv_pkg::ROW_OUT_BITS-1:0]              out_row,
  output logic [imconv_pkg::COL_OUT_BITS-1:0]              out_col,
  output logic                                             frame_end
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int CW    = $clog2(MAX_WIDTH) + 1;
  localparam int RW    = imconv_pkg::HEIGHT_BITS;
  localparam int RING  = MAX_KERNEL + 1;
  localparam int RB    = $clog2(RING);
  localparam int KB    = $clog2(MAX_KERNEL + 1);
  localparam int NCOEF = MAX_KERNEL * MAX_KERNEL;
  localparam int PW    = COEF_BITS + imconv_pkg::PIX_BITS + 1;
  localparam int CSW   = PW + $clog2(MAX_KERNEL + 1);
  localparam int TW    = CSW + $clog2(MAX_KERNEL + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers. Values are clamped into range on the way in, and
  // every write restarts the frame.
  // ---------------------------------------------------------------------------
  logic [imconv_pkg::WIDTH_BITS-1:0]  image_width;
  logic [imconv_pkg::HEIGHT_BITS-1:0] image_height;
  logic [KB-1:0]                      kernel_rows;
  logic [KB-1:0]                      kernel_cols;

  logic [imconv_pkg::WIDTH_BITS-1:0]  width_clamped;
  logic [imconv_pkg::HEIGHT_BITS-1:0] height_clamped;
  logic [KB-1:0]                      ksize_clamped;

  always_comb begin
    int wv;
    int hv;
    int kv;
    wv = int'(cfg_data[imconv_pkg::WIDTH_BITS-1:0]);
    hv = int'(cfg_data[imconv_pkg::HEIGHT_BITS-1:0]);
    kv = int'(cfg_data[imconv_pkg::KSIZE_BITS-1:0]);
    if (wv < 1) wv = 1;
    if (wv > MAX_WIDTH) wv = MAX_WIDTH;
    if (hv < 1) hv = 1;
    if (hv > imconv_pkg::MAX_HEIGHT) hv = imconv_pkg::MAX_HEIGHT;
    if (kv < 1) kv = 1;
    if (kv > MAX_KERNEL) kv = MAX_KERNEL;
    width_clamped  = imconv_pkg::WIDTH_BITS'(wv);
    height_clamped = imconv_pkg::HEIGHT_BITS'(hv);
    ksize_clamped  = KB'(kv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= imconv_pkg::WIDTH_BITS'(1024);
      image_height <= imconv_pkg::HEIGHT_BITS'(1024);
      kernel_rows  <= KB'(3);
      kernel_cols  <= KB'(3);
    end else if (cfg_we) begin
      case (cfg_index)
        imconv_pkg::REG_WIDTH:  image_width  <= width_clamped;
        imconv_pkg::REG_HEIGHT: image_height <= height_clamped;
        imconv_pkg::REG_KROWS:  kernel_rows  <= ksize_clamped;
        imconv_pkg::REG_KCOLS:  kernel_cols  <= ksize_clamped;
        default: ;
      endcase
    end
  end

  // Derived geometry: kernel centre and reach below and to the right of it.
  logic [CW-1:0] w_last;
  logic [RW-1:0] h_last;
  logic [KB-1:0] cy, cx, down, right;

  assign w_last = CW'(image_width - imconv_pkg::WIDTH_BITS'(1));
  assign h_last = image_height - RW'(1);
  assign cy     = kernel_rows >> 1;
  assign cx     = kernel_cols >> 1;
  assign down   = kernel_rows - KB'(1) - cy;
  assign right  = kernel_cols - KB'(1) - cx;

  // ---------------------------------------------------------------------------
  // Pipeline control. The fetch, window and result stages hold while a finished result waits.
  // ---------------------------------------------------------------------------
  logic freeze;
  logic busy;
  logic acc;
  logic j_free;

  logic          j_valid, j_first, j_end;
  logic [KB-1:0] j_cnt;
  logic [CW-1:0] j_fcol, j_col;
  logic [RW-1:0] j_row;
  logic [RB-1:0] j_bank;

  logic f_valid, f_first, f_last, f_colok, f_end;
  logic [RW-1:0] f_row;
  logic [CW-1:0] f_col;
  logic [RB-1:0] f_sel   [MAX_KERNEL];
  logic          f_rowok [MAX_KERNEL];

  logic          w_valid, p_valid, s_valid, t_valid;
  logic          w_end, p_end, s_end, t_end;
  logic [RW-1:0] w_row, p_row, s_row, t_row;
  logic [CW-1:0] w_col, p_col, s_col, t_col;
  logic signed [TW-1:0] t_sum;

  assign freeze = out_valid && out_stall;
  assign busy   = j_valid || f_valid || w_valid || p_valid || s_valid || t_valid;
  assign j_free = !j_valid || (j_cnt == KB'(1) && !freeze);

  // A coefficient load waits until every item in flight has used the old set.
  assign in_stall = !j_free || (command == imconv_pkg::CMD_LOAD && busy);
  assign acc      = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Coefficient store.
  // ---------------------------------------------------------------------------
  logic [COEF_BITS-1:0] coef [NCOEF];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NCOEF; k++) begin
        coef[k] <= '0;
      end
    end else if (acc && command == imconv_pkg::CMD_LOAD) begin
      for (int k = 0; k < NCOEF; k++) begin
        if (int'(coeff_index) == k) begin
          coef[k] <= coeff_value;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input and output positions as row and column counters. The row bank of the
  // line store follows the row count round the ring.
  // ---------------------------------------------------------------------------
  logic [RW-1:0] in_row, pos_row, nin_row;
  logic [CW-1:0] in_col, pos_col, nin_col;
  logic [RB-1:0] in_bank, pos_bank, nin_bank;
  logic          pix_wr, tick, ready, emit, job_last;
  logic [RW-1:0] lr;
  logic [CW-1:0] lc;
  logic [RW:0]   lr_raw;
  logic [CW:0]   lc_raw;

  assign pix_wr = acc && command == imconv_pkg::CMD_PIXEL && in_row < image_height;
  assign tick   = acc && (command == imconv_pkg::CMD_PIXEL ||
                          command == imconv_pkg::CMD_DRAIN);

  always_comb begin
    nin_row  = in_row;
    nin_col  = in_col;
    nin_bank = in_bank;
    if (pix_wr) begin
      if (in_col == w_last) begin
        nin_col  = '0;
        nin_row  = in_row + RW'(1);
        nin_bank = (in_bank == RB'(RING - 1)) ? '0 : in_bank + RB'(1);
      end else begin
        nin_col = in_col + CW'(1);
      end
    end
  end

  // The result for the current output position is released once the bottom
  // right pixel of its window, clipped to the frame, has arrived.
  assign lr_raw   = {1'b0, pos_row} + (RW + 1)'(down);
  assign lr       = (lr_raw > {1'b0, h_last}) ? h_last : lr_raw[RW-1:0];
  assign lc_raw   = {1'b0, pos_col} + (CW + 1)'(right);
  assign lc       = (lc_raw > {1'b0, w_last}) ? w_last : lc_raw[CW-1:0];
  assign ready    = nin_row > lr || (nin_row == lr && nin_col > lc);
  assign emit     = tick && ready;
  assign job_last = pos_row == h_last && pos_col == w_last;

  always_ff @(posedge clk) begin
    if (rst || (cfg_we && !rst)) begin
      in_row   <= '0;
      in_col   <= '0;
      in_bank  <= '0;
      pos_row  <= '0;
      pos_col  <= '0;
      pos_bank <= '0;
    end else if (emit && job_last) begin
      in_row   <= '0;
      in_col   <= '0;
      in_bank  <= '0;
      pos_row  <= '0;
      pos_col  <= '0;
      pos_bank <= '0;
    end else begin
      in_row  <= nin_row;
      in_col  <= nin_col;
      in_bank <= nin_bank;
      if (emit) begin
        if (pos_col == w_last) begin
          pos_col  <= '0;
          pos_row  <= pos_row + RW'(1);
          pos_bank <= (pos_bank == RB'(RING - 1)) ? '0 : pos_bank + RB'(1);
        end else begin
          pos_col <= pos_col + CW'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Fetch sequencer. A new output row clears the window and preloads the
  // columns up to the kernel's right reach; otherwise one column is fetched.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      j_valid <= 1'b0;
    end else if (emit) begin
      j_valid <= 1'b1;
      if (pos_col == '0) begin
        j_cnt   <= right + KB'(1);
        j_fcol  <= '0;
        j_first <= 1'b1;
      end else begin
        j_cnt   <= KB'(1);
        j_fcol  <= CW'(pos_col + CW'(right));
        j_first <= 1'b0;
      end
    end else if (j_valid && !freeze) begin
      j_cnt   <= j_cnt - KB'(1);
      j_fcol  <= j_fcol + CW'(1);
      j_first <= 1'b0;
      if (j_cnt == KB'(1)) begin
        j_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      j_row  <= pos_row;
      j_col  <= pos_col;
      j_bank <= pos_bank;
      j_end  <= job_last;
    end
  end

  // Row bank and in-frame flag of every window row for the job in fetch.
  logic [RB-1:0] sel_next   [MAX_KERNEL];
  logic          rowok_next [MAX_KERNEL];

  always_comb begin
    for (int i = 0; i < MAX_KERNEL; i++) begin
      int          b;
      logic [RW:0] rr;
      b  = int'(j_bank) + RING + i - int'(cy);
      if (b >= RING) b = b - RING;
      if (b >= RING) b = b - RING;
      sel_next[i]   = RB'(b);
      rr            = {1'b0, j_row} + (RW + 1)'(i);
      rowok_next[i] = (i < int'(kernel_rows)) && (rr >= (RW + 1)'(cy)) &&
                      (rr - (RW + 1)'(cy) <= {1'b0, h_last});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (!freeze) begin
      f_valid <= j_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!freeze) begin
      f_first <= j_first;
      f_last  <= j_cnt == KB'(1);
      f_colok <= j_fcol <= w_last;
      f_row   <= j_row;
      f_col   <= j_col;
      f_end   <= j_end;
      for (int i = 0; i < MAX_KERNEL; i++) begin
        f_sel[i]   <= sel_next[i];
        f_rowok[i] <= rowok_next[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: one bank for each row of the ring.
  // ---------------------------------------------------------------------------
  logic [imconv_pkg::PIX_BITS-1:0] bank_rd [RING];

  for (genvar g = 0; g < RING; g++) begin : g_bank
    imconv_line_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
    ) u_mem (
      .clk   (clk),
      .we    (pix_wr && in_bank == RB'(g)),
      .waddr (in_col[AW-1:0]),
      .wdata (pixel_in),
      .re    (j_valid && !freeze),
      .raddr (j_fcol[AW-1:0]),
      .rdata (bank_rd[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Window: a row of column cells. Each cycle with fetched data every cell takes
  // its right neighbour's column, or zero on a row's first fetch; the cell at the
  // kernel's right edge takes the new column. Out-of-frame pixels enter as zero.
  // ---------------------------------------------------------------------------
  logic [MAX_KERNEL-1:0][imconv_pkg::PIX_BITS-1:0] new_col;
  logic [MAX_KERNEL-1:0][imconv_pkg::PIX_BITS-1:0] cell_pix [MAX_KERNEL];
  logic signed [CSW-1:0]                           col_sum  [MAX_KERNEL];

  always_comb begin
    for (int i = 0; i < MAX_KERNEL; i++) begin
      new_col[i] = (f_rowok[i] && f_colok) ? bank_rd[f_sel[i]] : '0;
    end
  end

  for (genvar j = 0; j < MAX_KERNEL; j++) begin : g_cell
    imconv_pkg::cell_ctrl_t                          ctrl;
    logic [MAX_KERNEL-1:0][imconv_pkg::PIX_BITS-1:0] neigh;
    logic [MAX_KERNEL-1:0][COEF_BITS-1:0]            ccoef;

    assign ctrl.shift  = f_valid;
    assign ctrl.clear  = f_first;
    assign ctrl.insert = KB'(j) == kernel_cols - KB'(1);

    if (j == MAX_KERNEL - 1) begin : g_edge
      assign neigh = '0;
    end else begin : g_inner
      assign neigh = cell_pix[j+1];
    end

    // Coefficients outside the kernel in use are masked to zero.
    always_comb begin
      for (int i = 0; i < MAX_KERNEL; i++) begin
        ccoef[i] = (i < int'(kernel_rows) && j < int'(kernel_cols)) ?
                   coef[i * MAX_KERNEL + j] : '0;
      end
    end

    imconv_cell #(
      .MAX_KERNEL (MAX_KERNEL),
      .COEF_BITS  (COEF_BITS),
      .CSW        (CSW)
    ) u_cell (
      .clk      (clk),
      .en       (!freeze),
      .ctrl     (ctrl),
      .neigh_in (neigh),
      .new_col  (new_col),
      .coef     (ccoef),
      .pix      (cell_pix[j]),
      .col_sum  (col_sum[j])
    );
  end

  // ---------------------------------------------------------------------------
  // Result stages: window complete, products, column sums, total, output.
  // ---------------------------------------------------------------------------
  logic signed [TW-1:0] total;

  always_comb begin
    total = '0;
    for (int j = 0; j < MAX_KERNEL; j++) begin
      total = total + TW'(col_sum[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
      p_valid <= 1'b0;
      s_valid <= 1'b0;
      t_valid <= 1'b0;
    end else if (!freeze) begin
      w_valid <= f_valid && f_last;
      p_valid <= w_valid;
      s_valid <= p_valid;
      t_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!freeze) begin
      w_row <= f_row;
      w_col <= f_col;
      w_end <= f_end;
      p_row <= w_row;
      p_col <= w_col;
      p_end <= w_end;
      s_row <= p_row;
      s_col <= p_col;
      s_end <= p_end;
      t_row <= s_row;
      t_col <= s_col;
      t_end <= s_end;
      t_sum <= total;
    end
  end

  // Round to nearest with halves up, then saturate to the pixel range.
  logic signed [TW:0]               rounded;
  logic [imconv_pkg::PIX_BITS-1:0]  pix_sat;

  always_comb begin
    rounded = (TW + 1)'(t_sum) + (TW + 1)'(imconv_pkg::ROUND_HALF);
    if (rounded < 0) begin
      pix_sat = '0;
    end else if ((rounded >>> imconv_pkg::FRAC_BITS) > (TW + 1)'(imconv_pkg::PIX_MAX)) begin
      pix_sat = imconv_pkg::PIX_BITS'(imconv_pkg::PIX_MAX);
    end else begin
      pix_sat = rounded[imconv_pkg::FRAC_BITS +: imconv_pkg::PIX_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!freeze) begin
      out_valid <= t_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!freeze) begin
      pixel_out <= pix_sat;
      out_row   <= imconv_pkg::ROW_OUT_BITS'(t_row);
      out_col   <= imconv_pkg::COL_OUT_BITS'(t_col);
      frame_end <= t_end;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_fetch_count : assert property (@(posedge clk) disable iff (rst)
    j_valid |-> j_cnt != '0)
    else $error("fetch sequencer holds a job with no fetch left");

  a_load_idle : assert property (@(posedge clk) disable iff (rst)
    (acc && command == imconv_pkg::CMD_LOAD) |-> !busy)
    else $error("coefficient load taken while items are in flight");

  a_stage_move : assert property (@(posedge clk) disable iff (rst)
    (p_valid && !freeze) |=> s_valid)
    else $error("column sum stage lost an item");

endmodule

`default_nettype wire

FILE: verif/image_convolution_2d_checker.sv
// Checker for the 2-D convolution block: watches both channels, predicts and compares results.
`timescale 1ns / 1ps

module image_convolution_2d_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [4:0]  coeff_index,
  input  wire logic [15:0] coeff_value,
  input  wire logic [7:0]  pixel_in,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [7:0]  pixel_out,
  input  wire logic [11:0] out_row,
  input  wire logic [9:0]  out_col,
  input  wire logic        frame_end,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [7:0]  pix;
    logic [11:0] row;
    logic [9:0]  col;
    logic        last;
  } filtered_t;

  filtered_t   filtered_q[$];
  logic [7:0]  row_ring[6][1024];
  logic signed [15:0] kernel[25];
  int          width, height, krows, kcols;
  int          pixels_in, pixels_out;

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Advances the convolution state by one accepted item.
  task automatic convolve_item(logic [1:0] cmd, logic [4:0] idx, logic [15:0] val,
                               logic [7:0] pix);
    int total, orow, ocol, cy, cx, lr, lc, rr, cc;
    longint acc;
    filtered_t res;
    total = width * height;
    acc = 0;
    if (cmd == imconv_pkg::CMD_LOAD) begin
      if (idx < 25) kernel[idx] = val;
      return;
    end
    if (cmd == imconv_pkg::CMD_NONE) return;
    if (cmd == imconv_pkg::CMD_PIXEL && pixels_in < total) begin
      row_ring[(pixels_in / width) % 6][pixels_in % width] = pix;
      pixels_in++;
    end
    if (pixels_out >= total) return;
    orow = pixels_out / width;
    ocol = pixels_out % width;
    cy = krows / 2;
    cx = kcols / 2;
    lr = clamp(orow + krows - 1 - cy, 0, height - 1);
    lc = clamp(ocol + kcols - 1 - cx, 0, width - 1);
    if (pixels_in <= lr * width + lc) return;
    for (int m = 0; m < krows; m++) begin
      rr = orow + m - cy;
      if (rr < 0 || rr >= height) continue;
      for (int n = 0; n < kcols; n++) begin
        cc = ocol + n - cx;
        if (cc < 0 || cc >= width) continue;
        acc += longint'(row_ring[rr % 6][cc]) * longint'(kernel[m * 5 + n]);
      end
    end
    acc = acc + imconv_pkg::ROUND_HALF;
    if (acc < 0) res.pix = 8'd0;
    else res.pix = ((acc >>> imconv_pkg::FRAC_BITS) > imconv_pkg::PIX_MAX) ?
                   8'(imconv_pkg::PIX_MAX) : 8'(acc >>> imconv_pkg::FRAC_BITS);
    res.row = orow[11:0];
    res.col = ocol[9:0];
    pixels_out++;
    res.last = (pixels_out == total);
    if (res.last) begin
      pixels_out = 0;
      pixels_in = 0;
    end
    filtered_q.push_back(res);
  endtask

  always @(posedge clk) begin
    filtered_t exp_res;
    if (rst) begin
      filtered_q.delete();
      foreach (kernel[i]) kernel[i] = '0;
      width = 1024; height = 1024; krows = 3; kcols = 3;
      pixels_in = 0; pixels_out = 0;
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          imconv_pkg::REG_WIDTH:  width  = clamp(int'(cfg_data[10:0]), 1, 1024);
          imconv_pkg::REG_HEIGHT: height = clamp(int'(cfg_data), 1, imconv_pkg::MAX_HEIGHT);
          imconv_pkg::REG_KROWS:  krows  = clamp(int'(cfg_data[2:0]), 1, 5);
          default:                kcols  = clamp(int'(cfg_data[2:0]), 1, 5);
        endcase
        pixels_in = 0;
        pixels_out = 0;
      end
      if (in_valid && !in_stall) convolve_item(command, coeff_index, coeff_value, pixel_in);
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected result pixel %0d row %0d col %0d end %0d", $time,
                   pixel_out, out_row, out_col, frame_end);
          fail_count++;
        end else begin
          exp_res = filtered_q.pop_front();
          if (exp_res.pix != pixel_out || exp_res.row != out_row ||
              exp_res.col != out_col || exp_res.last != frame_end) begin
            $display("%0t: expected pixel %0d row %0d col %0d end %0d, got %0d %0d %0d %0d",
                     $time, exp_res.pix, exp_res.row, exp_res.col, exp_res.last,
                     pixel_out, out_row, out_col, frame_end);
            fail_count++;
          end
        end
      end
    end
    pending = filtered_q.size();
  end

endmodule

FILE: verif/testbench.sv
// Top of the testbench for the 2-D convolution block: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module testbench;

  // A generous bound on the whole run, in clock cycles.
  localparam int CYCLE_LIMIT = 600000;
  // Cycles to let pass once nothing is expected, covering the block's latency.
  localparam int SETTLE_CYCLES = 16;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  command;
  logic [4:0]  coeff_index;
  logic [15:0] coeff_value;
  logic [7:0]  pixel_in;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  pixel_out;
  logic [11:0] out_row;
  logic [9:0]  out_col;
  logic        frame_end;

  int fail_count;
  int pending;
  int cycles = 0;
  int items_sent;
  // When set, neither side idles; when hold_req is raised the receiver holds off once.
  logic quiet;
  logic hold_req;
  logic hold_done;
  int   hold_left;

  image_convolution_2d_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .command(command),
    .coeff_index(coeff_index), .coeff_value(coeff_value), .pixel_in(pixel_in),
    .out_valid(out_valid), .out_stall(out_stall), .pixel_out(pixel_out),
    .out_row(out_row), .out_col(out_col), .frame_end(frame_end)
  );

  image_convolution_2d_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .command(command),
    .coeff_index(coeff_index), .coeff_value(coeff_value), .pixel_in(pixel_in),
    .out_valid(out_valid), .out_stall(out_stall), .pixel_out(pixel_out),
    .out_row(out_row), .out_col(out_col), .frame_end(frame_end),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random, except in quiet stretches. Once asked, it holds off
  // for a long stretch of its own counting, so that the block backs up and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= 300;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 30);
    end
  end

  // The run is cut short if it goes on far longer than any correct run could.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offers one item and returns once it has been accepted. The sender may idle first.
  task automatic send_item(imconv_pkg::cmd_t cmd, logic [4:0] idx, logic [15:0] val,
                           logic [7:0] pix);
    while (!quiet && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    coeff_index <= idx;
    coeff_value <= val;
    pixel_in    <= pix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd != imconv_pkg::CMD_NONE) items_sent++;
  endtask

  // Lowers valid and waits until every expected item has come back and the pipe is empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // A coefficient: mostly modest, so results spread across the range, sometimes any 16 bits.
  function automatic logic [15:0] pick_coeff();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return 16'($signed($urandom_range(600)) - 300);
    if (sel < 85) return 16'($signed($urandom_range(4096)) - 2048);
    return 16'($urandom);
  endfunction

  // Items that may fall between pixels: ignored commands, early drains, live kernel changes.
  task automatic send_noise();
    case ($urandom_range(2))
      0: send_item(imconv_pkg::CMD_NONE, 5'($urandom), 16'($urandom), 8'($urandom));
      1: send_item(imconv_pkg::CMD_DRAIN, 5'($urandom), 16'($urandom), 8'($urandom));
      default: send_item(imconv_pkg::CMD_LOAD, 5'($urandom_range(31)), pick_coeff(),
                         8'($urandom));
    endcase
  endtask

  // One phase: new register values written while idle, a fresh kernel, one frame of
  // pixels with noise in between, a few surplus pixels, then drain ticks to flush it.
  task automatic run_frame(logic [12:0] raw_w, logic [12:0] raw_h,
                           logic [12:0] raw_kr, logic [12:0] raw_kc);
    int w, h, npix;
    w = (raw_w[10:0] == 0) ? 1 : ((raw_w[10:0] > 1024) ? 1024 : int'(raw_w[10:0]));
    h = (raw_h == 0) ? 1 : ((raw_h > imconv_pkg::MAX_HEIGHT) ? imconv_pkg::MAX_HEIGHT
                                                             : int'(raw_h));
    npix = w * h;
    wait_idle();
    write_reg(imconv_pkg::REG_WIDTH, raw_w);
    write_reg(imconv_pkg::REG_HEIGHT, raw_h);
    write_reg(imconv_pkg::REG_KROWS, raw_kr);
    write_reg(imconv_pkg::REG_KCOLS, raw_kc);
    for (int i = 0; i < 25; i++) send_item(imconv_pkg::CMD_LOAD, 5'(i), pick_coeff(),
                                           8'($urandom));
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(99) < 8) send_noise();
      send_item(imconv_pkg::CMD_PIXEL, 5'($urandom), 16'($urandom), 8'($urandom));
    end
    // Surplus pixels are dropped while outputs are still owed, or open the next frame.
    repeat ($urandom_range(2)) send_item(imconv_pkg::CMD_PIXEL, 5'($urandom), 16'($urandom),
                                         8'($urandom));
    repeat (2 * w + 4) send_item(imconv_pkg::CMD_DRAIN, 5'($urandom), 16'($urandom),
                                 8'($urandom));
  endtask

  initial begin
    items_sent  = 0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = imconv_pkg::REG_WIDTH;
    cfg_data    = '0;
    in_valid    = 1'b0;
    command     = imconv_pkg::CMD_NONE;
    coeff_index = '0;
    coeff_value = '0;
    pixel_in    = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: a 3x3 frame through a 3x3 kernel. The coefficients take their
    // extremes, out-of-store loads and the ignored command are offered, a drain comes
    // with nothing ready, and the centre tap is changed in the middle of the frame.
    write_reg(imconv_pkg::REG_WIDTH, 13'd3);
    write_reg(imconv_pkg::REG_HEIGHT, 13'd3);
    send_item(imconv_pkg::CMD_LOAD, 5'd0, 16'h8000, 8'd0);
    send_item(imconv_pkg::CMD_LOAD, 5'd24, 16'h7fff, 8'd0);
    send_item(imconv_pkg::CMD_LOAD, 5'd6, 16'h0100, 8'd0);
    send_item(imconv_pkg::CMD_LOAD, 5'd25, 16'h7fff, 8'd0);
    send_item(imconv_pkg::CMD_LOAD, 5'd31, 16'hffff, 8'd0);
    send_item(imconv_pkg::CMD_NONE, 5'd31, 16'hffff, 8'hff);
    send_item(imconv_pkg::CMD_DRAIN, 5'd0, 16'd0, 8'd0);
    send_item(imconv_pkg::CMD_PIXEL, 5'd0, 16'd0, 8'd255);
    send_item(imconv_pkg::CMD_PIXEL, 5'd0, 16'd0, 8'd0);
    send_item(imconv_pkg::CMD_PIXEL, 5'd0, 16'd0, 8'd128);
    send_item(imconv_pkg::CMD_PIXEL, 5'd0, 16'd0, 8'd255);
    send_item(imconv_pkg::CMD_LOAD, 5'd6, 16'h0180, 8'd0);
    send_item(imconv_pkg::CMD_LOAD, 5'd12, 16'h7fff, 8'd0);
    for (int i = 0; i < 5; i++) send_item(imconv_pkg::CMD_PIXEL, 5'd0, 16'd0, 8'(i * 60));
    repeat (8) send_item(imconv_pkg::CMD_DRAIN, 5'd0, 16'd0, 8'd0);

    // Extremes of the registers, with clamping at both ends and masking of the
    // bits above each register's width.
    run_frame(13'd1, 13'd1, 13'd1, 13'd1);
    run_frame(13'd0, 13'd0, 13'd0, 13'd0);
    run_frame(13'd4, 13'd4, 13'd5, 13'd5);
    run_frame(13'd3, 13'd2, 13'd7, 13'd7);
    run_frame(13'h0803, 13'd1, 13'd2, 13'd4);
    run_frame(13'd40, 13'd2, 13'd5, 13'd5);
    run_frame(13'd1, 13'd9, 13'd5, 13'd1);

    // A frame with no idling on either side.
    quiet = 1'b1;
    run_frame(13'd16, 13'd6, 13'd3, 13'd5);
    quiet = 1'b0;

    // The receiver holds off while the sender keeps offering a sizeable frame.
    hold_req = 1'b1;
    run_frame(13'd24, 13'd10, 13'd5, 13'd3);

    // Random phases of small frames, with the odd out-of-range register value.
    while (items_sent < 1500) begin
      run_frame(($urandom_range(9) == 0) ? 13'($urandom) & 13'h0007 : 13'($urandom_range(1, 12)),
                13'($urandom_range(1, 8)),
                13'($urandom_range(0, 7)), 13'($urandom_range(0, 7)));
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
